[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge outside reset.
`define MSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on each rising edge, reset included.
`define MSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[sv/mss_pkg.sv]
// Shared constants and types for the median string search block.
`default_nettype none
package mss_pkg;
  localparam int MAX_PATTERN = 8;
  localparam int MAX_SEQS    = 16;
  localparam int MAX_SEQ_LEN = 64;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int PAT_W       = 2 * MAX_PATTERN;
  localparam int DIST_W      = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_NUM_SEQS       = 2'd1;
  localparam logic [1:0] REG_SEQ_LENGTH     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Tag that travels beside each base read from the store.
  typedef struct packed {
    logic             valid;
    logic             win;
    logic             seqend;
    logic             candend;
    logic             final_cand;
    logic [PAT_W-1:0] cand;
  } tag_t;
endpackage
`default_nettype wire

[sv/mss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mss_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/mss_cell.sv]
// One cell of the window row: holds a base and flags a mismatch against its pattern base.
`default_nettype none
module mss_cell import mss_pkg::*; (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [1:0] base_in,
  input  wire logic [1:0] pat,
  input  wire logic       active,
  output logic      [1:0] base_out,
  output logic            mismatch
);
  logic [1:0] base_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      base_q <= base_in;
    end
  end

  assign base_out = base_q;
  assign mismatch = active && (base_q != pat);
endmodule
`default_nettype wire

[sv/mss_chain.sv]
// Row of window cells and the count of mismatching positions.
`default_nettype none
module mss_chain import mss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire logic [1:0]        base_in,
  input  wire logic [PAT_W-1:0]  pattern,
  input  wire logic [3:0]        plen,
  output logic      [DIST_W-1:0] miss_cnt
);
  logic [1:0]             link [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] miss;

  assign link[0] = base_in;

  // Cell k holds the k-th newest base, matching pattern base k.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    mss_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .base_in  (link[k]),
      .pat      (pattern[2*k+1:2*k]),
      .active   (k < plen),
      .base_out (link[k+1]),
      .mismatch (miss[k])
    );
  end

  always_comb begin
    miss_cnt = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      miss_cnt = miss_cnt + DIST_W'(miss[k]);
    end
  end
endmodule
`default_nettype wire

[sv/median_string_search.sv]
// A bad setup gives its error result in the cycle after the last base.
// A search gives its result once all 4^pattern_length candidates have been scored over every sequence.
// Loading takes one base per cycle; the search streams one stored base per cycle through
// the cell row, bounded by the single read port of the base store.
// Results cannot be stalled. Synchronous reset restores the registers to 4, 1, 8 and
// clears the search; stored bases are kept undefined until written.
`default_nettype none
module median_string_search import mss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  base,
  input  wire logic        last,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [6:0]  wr_data,
  output logic             done,
  output logic [15:0]      best_pattern,
  output logic [7:0]       best_score,
  output logic             error
);
  state_t             state;
  logic [3:0]         pattern_length;
  logic [4:0]         num_seqs;
  logic [6:0]         seq_length;
  logic [ADDR_W-1:0]  load_position;
  logic [PAT_W-1:0]   candidate;
  logic [4:0]         seq_idx;
  logic [6:0]         pos;
  logic [ADDR_W-1:0]  raddr;
  tag_t               p1, p2;
  logic [DIST_W-1:0]  seq_minimum;
  logic [7:0]         running_total;
  logic [7:0]         best_total;
  logic [PAT_W-1:0]   lead_word;
  logic [1:0]         rdata;
  logic [DIST_W-1:0]  miss_cnt;
  logic [DIST_W-1:0]  cur_min;
  logic [7:0]         cand_total;
  logic               better;
  logic [PAT_W:0]     cand_full;
  logic [PAT_W-1:0]   cand_last;
  logic               accept;
  logic               bad;
  logic               seqend, candend, final_cand, win;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign bad = (pattern_length == 4'd0) || (pattern_length > 4'(MAX_PATTERN)) ||
               (num_seqs == 5'd0) || (num_seqs > 5'(MAX_SEQS)) ||
               (seq_length == 7'd0) || (seq_length > 7'(MAX_SEQ_LEN)) ||
               (seq_length < {3'd0, pattern_length});

  assign cand_full  = ((PAT_W+1)'(1) << {pattern_length, 1'b0}) - (PAT_W+1)'(1);
  assign cand_last  = cand_full[PAT_W-1:0];
  assign seqend     = (pos == seq_length - 7'd1);
  assign candend    = seqend && (seq_idx == num_seqs - 5'd1);
  assign final_cand = candend && (candidate == cand_last);
  assign win        = ((pos + 7'd1) >= {3'd0, pattern_length});

  assign cur_min    = (miss_cnt < seq_minimum) ? miss_cnt : seq_minimum;
  assign cand_total = running_total + 8'(cur_min);
  assign better     = cand_total < best_total;

  mss_ram #(.WIDTH(2), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (load_position),
    .wdata (base),
    .raddr (raddr),
    .rdata (rdata)
  );

  mss_chain u_chain (
    .clk      (clk),
    .shift    (p1.valid),
    .base_in  (rdata),
    .pattern  (p2.cand),
    .plen     (pattern_length),
    .miss_cnt (miss_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 4'd4;
      num_seqs       <= 5'd1;
      seq_length     <= 7'd8;
    end else if (wr_en) begin
      case (wr_index)
        REG_PATTERN_LENGTH: pattern_length <= wr_data[3:0];
        REG_NUM_SEQS:       num_seqs       <= wr_data[4:0];
        REG_SEQ_LENGTH:     seq_length     <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      load_position <= '0;
      candidate     <= '0;
      seq_idx       <= '0;
      pos           <= '0;
      raddr         <= '0;
      p1            <= '0;
      p2            <= '0;
      seq_minimum   <= '1;
      running_total <= '0;
      best_total    <= '1;
      lead_word     <= '0;
      done          <= 1'b0;
      error         <= 1'b0;
      best_pattern  <= '0;
      best_score    <= '0;
    end else begin
      done <= 1'b0;
      p2   <= p1;
      p1.valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            load_position <= load_position + ADDR_W'(1);
            if (last) begin
              load_position <= '0;
              candidate     <= '0;
              seq_idx       <= '0;
              pos           <= '0;
              raddr         <= '0;
              seq_minimum   <= '1;
              running_total <= '0;
              best_total    <= '1;
              lead_word     <= '0;
              if (bad) begin
                done          <= 1'b1;
                error         <= 1'b1;
                best_pattern  <= '0;
                best_score    <= '0;
              end else begin
                state <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          // issue one store read per cycle, tagged with its window position
          p1.valid      <= 1'b1;
          p1.win        <= win;
          p1.seqend     <= seqend;
          p1.candend    <= candend;
          p1.final_cand <= final_cand;
          p1.cand       <= candidate;
          raddr         <= raddr + ADDR_W'(1);
          if (seqend) begin
            pos <= '0;
            if (candend) begin
              seq_idx   <= '0;
              raddr     <= '0;
              candidate <= candidate + PAT_W'(1);
              if (final_cand) begin
                state <= ST_DRAIN;
              end
            end else begin
              seq_idx <= seq_idx + 5'd1;
            end
          end else begin
            pos <= pos + 7'd1;
          end
        end
        ST_DRAIN: ;
        default: state <= ST_IDLE;
      endcase

      if (p2.valid && p2.win) begin
        if (p2.seqend) begin
          seq_minimum <= '1;
          if (p2.candend) begin
            running_total <= '0;
            if (p2.final_cand) begin
              done          <= 1'b1;
              error         <= 1'b0;
              best_pattern  <= better ? p2.cand : lead_word;
              best_score    <= better ? cand_total : best_total;
              best_total    <= '1;
              lead_word     <= '0;
              candidate     <= '0;
              state         <= ST_IDLE;
            end else if (better) begin
              best_total <= cand_total;
              lead_word  <= p2.cand;
            end
          end else begin
            running_total <= cand_total;
          end
        end else begin
          seq_minimum <= cur_min;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sv/mss_checker.sv]
// Port-level checker for the median string search block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        error,
  input wire logic [15:0] best_pattern,
  input wire logic [7:0]  best_score
);
  `MSS_ASSERT(a_done_idle, clk, rst, done |-> !busy)
  `MSS_ASSERT(a_end_gives_result, clk, rst, $fell(busy) |-> done)
  `MSS_ASSERT(a_error_zero, clk, rst, (done && error) |-> (best_pattern == '0 && best_score == '0))
  `MSS_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!done && !busy))
endmodule

bind median_string_search mss_checker u_mss_checker (.*);
`default_nettype wire
